FILE: hdl/min_priority_queue_sorted_macros.svh
// assertion macros for the sorted priority queue checker
`ifndef MIN_PRIORITY_QUEUE_SORTED_MACROS_SVH
`define MIN_PRIORITY_QUEUE_SORTED_MACROS_SVH

// same-cycle implication, reset masks the check
`define MPQS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("queue check failed");

// next-cycle implication
`define MPQS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("queue check failed");

`endif

FILE: hdl/mpqs_pkg.sv
// shared types and codes for the sorted priority queue
`default_nettype none
package mpqs_pkg;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_POP    = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_POPPED   = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctrl_type;

endpackage
`default_nettype wire

FILE: hdl/mpqs_cell.sv
// one slot of the sorted chain: compare against the new key and shift
`default_nettype none
module mpqs_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int PRIO_WIDTH = 16
) (
   input  logic                      clock,
   input  mpqs_pkg::cell_ctrl_type   ctrl,
   input  logic                      occupied,
   input  logic [DATA_WIDTH-1:0]     new_data,
   input  logic [PRIO_WIDTH-1:0]     new_prio,
   input  logic [DATA_WIDTH-1:0]     left_data,
   input  logic [PRIO_WIDTH-1:0]     left_prio,
   input  logic                      left_lt,
   input  logic [DATA_WIDTH-1:0]     right_data,
   input  logic [PRIO_WIDTH-1:0]     right_prio,
   output logic [DATA_WIDTH-1:0]     data,
   output logic [PRIO_WIDTH-1:0]     prio,
   output logic                      lt
);
   import mpqs_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic [PRIO_WIDTH-1:0] prio_ff;
   logic [PRIO_WIDTH-1:0] prio_in;

   // strictly lower stored priority keeps its place
   assign lt = occupied && ($signed(prio_ff) < $signed(new_prio));

   always_comb begin
      data_in = data_ff;
      prio_in = prio_ff;
      if (ctrl.insert) begin
         if (lt) begin
            data_in = data_ff;
            prio_in = prio_ff;
         end else if (left_lt) begin
            data_in = new_data;
            prio_in = new_prio;
         end else begin
            data_in = left_data;
            prio_in = left_prio;
         end
      end else if (ctrl.pop) begin
         data_in = right_data;
         prio_in = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   assign data = data_ff;
   assign prio = prio_ff;

endmodule
`default_nettype wire

FILE: hdl/min_priority_queue_sorted.sv
// a taken request beat registers its result, which is valid in the cycle after the beat
// throughput: one insert or pop per cycle when ready; cells compare, shift at once
// the request side stalls only while a result beat waits and rsp_ready is low
// reset clears the entry count and the result valid; cell contents need no reset
`default_nettype none
module min_priority_queue_sorted #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int PRIO_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [DATA_WIDTH-1:0]              req_item_data,
   input  logic signed [PRIO_WIDTH-1:0]       req_priority_req,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [DATA_WIDTH-1:0]              rsp_popped_data,
   output mpqs_pkg::status_type               rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_occupancy
);
   import mpqs_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff;
   logic [DATA_WIDTH-1:0] rsp_data_in;
   status_type            rsp_status_ff;
   status_type            rsp_status_in;
   logic [CW-1:0]         rsp_occ_ff;

   logic                  beat;
   logic                  is_pop;
   logic                  full;
   logic                  empty;
   cell_ctrl_type         ctrl;

   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [PRIO_WIDTH-1:0] cell_prio [DEPTH];
   logic                  cell_lt   [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign beat      = req_valid && req_ready;
   assign is_pop    = (func_type'(req_func) == FUNC_POP);
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);

   assign ctrl.insert = beat && !is_pop && !full;
   assign ctrl.pop    = beat && is_pop && !empty;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [DATA_WIDTH-1:0] l_data;
         logic [PRIO_WIDTH-1:0] l_prio;
         logic                  l_lt;
         logic [DATA_WIDTH-1:0] r_data;
         logic [PRIO_WIDTH-1:0] r_prio;

         if (gi == 0) begin : g_head
            assign l_data = req_item_data;
            assign l_prio = req_priority_req;
            assign l_lt   = 1'b1;
         end else begin : g_body
            assign l_data = cell_data[gi-1];
            assign l_prio = cell_prio[gi-1];
            assign l_lt   = cell_lt[gi-1];
         end

         if (gi == DEPTH - 1) begin : g_tail
            assign r_data = cell_data[gi];
            assign r_prio = cell_prio[gi];
         end else begin : g_mid
            assign r_data = cell_data[gi+1];
            assign r_prio = cell_prio[gi+1];
         end

         mpqs_cell #(
            .DATA_WIDTH(DATA_WIDTH),
            .PRIO_WIDTH(PRIO_WIDTH)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (count_ff > CW'(gi)),
            .new_data   (req_item_data),
            .new_prio   (req_priority_req),
            .left_data  (l_data),
            .left_prio  (l_prio),
            .left_lt    (l_lt),
            .right_data (r_data),
            .right_prio (r_prio),
            .data       (cell_data[gi]),
            .prio       (cell_prio[gi]),
            .lt         (cell_lt[gi])
         );
      end
   endgenerate

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (beat) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         priority if (ctrl.insert) begin
            count_in      = count_ff + CW'(1);
            rsp_status_in = STATUS_INSERTED;
         end else if (ctrl.pop) begin
            count_in      = count_ff - CW'(1);
            rsp_data_in   = cell_data[0];
            rsp_status_in = STATUS_POPPED;
         end else if (is_pop) begin
            rsp_status_in = STATUS_EMPTY;
         end else begin
            rsp_status_in = STATUS_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_occ_ff    <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_popped_data = rsp_data_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_occupancy   = rsp_occ_ff;

endmodule
`default_nettype wire

FILE: hdl/mpqs_checker.sv
// port-level checks for the sorted priority queue, bound to the top level
`default_nettype none
`include "min_priority_queue_sorted_macros.svh"
module mpqs_checker #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int PRIO_WIDTH = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_func,
   input logic [DATA_WIDTH-1:0]         req_item_data,
   input logic signed [PRIO_WIDTH-1:0]  req_priority_req,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [DATA_WIDTH-1:0]         rsp_popped_data,
   input mpqs_pkg::status_type          rsp_status,
   input logic [$clog2(DEPTH+1)-1:0]    rsp_occupancy
);
   import mpqs_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   // a stalled result beat holds
   `MPQS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_popped_data) && $stable(rsp_status) && $stable(rsp_occupancy))

   // every request beat gives a result beat in the next cycle
   `MPQS_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && req_ready, rsp_valid)

   // payload is zero unless a pop succeeded
   `MPQS_ASSERT_NOW(a_zero_data, clock, reset, rsp_valid && rsp_status != STATUS_POPPED, rsp_popped_data == '0)

   // pop on empty reports an empty queue
   `MPQS_ASSERT_NOW(a_empty_occ, clock, reset, rsp_valid && rsp_status == STATUS_EMPTY, rsp_occupancy == '0)

   // dropped insert reports a full queue
   `MPQS_ASSERT_NOW(a_full_occ, clock, reset, rsp_valid && rsp_status == STATUS_FULL, rsp_occupancy == CW'(DEPTH))

endmodule

bind min_priority_queue_sorted mpqs_checker #(
   .DEPTH(DEPTH),
   .DATA_WIDTH(DATA_WIDTH),
   .PRIO_WIDTH(PRIO_WIDTH)
) u_mpqs_checker (.*);
`default_nettype wire

FILE: bench/min_priority_queue_sorted_checker.sv
// checker for the sorted priority queue: tracks request beats, predicts results, compares them
`timescale 1ns / 100ps
module min_priority_queue_sorted_checker #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int PRIO_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_func,
   input  logic [DATA_WIDTH-1:0]        req_item_data,
   input  logic signed [PRIO_WIDTH-1:0] req_priority_req,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [DATA_WIDTH-1:0]        rsp_popped_data,
   input  mpqs_pkg::status_type         rsp_status,
   input  logic [$clog2(DEPTH+1)-1:0]   rsp_occupancy,
   output int                           mismatches,
   output int                           outstanding
);
   import mpqs_pkg::*;

   localparam int OCC_W = $clog2(DEPTH + 1);

   typedef struct {
      logic [DATA_WIDTH-1:0]        payload;
      logic signed [PRIO_WIDTH-1:0] prio;
   } held_entry_type;

   typedef struct {
      logic [DATA_WIDTH-1:0] popped_data;
      status_type            status;
      logic [OCC_W-1:0]      occupancy;
   } queue_outcome_type;

   held_entry_type    sorted_entries[$];
   queue_outcome_type awaited_outcomes[$];
   int                fail_tally = 0;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic queue_outcome_type apply_operation(input logic func,
                                                         input logic [DATA_WIDTH-1:0] data,
                                                         input logic signed [PRIO_WIDTH-1:0] prio);
      queue_outcome_type outcome;
      held_entry_type    entry;
      int                slot;
      outcome.popped_data = '0;
      if (func == FUNC_INSERT) begin
         if (sorted_entries.size() >= DEPTH) begin
            outcome.status = STATUS_FULL;
         end else begin
            // new entry goes ahead of stored entries of equal priority
            slot = 0;
            while (slot < sorted_entries.size() && sorted_entries[slot].prio < prio)
               slot++;
            entry.payload = data;
            entry.prio    = prio;
            sorted_entries.insert(slot, entry);
            outcome.status = STATUS_INSERTED;
         end
      end else if (sorted_entries.size() == 0) begin
         outcome.status = STATUS_EMPTY;
      end else begin
         entry = sorted_entries.pop_front();
         outcome.popped_data = entry.payload;
         outcome.status      = STATUS_POPPED;
      end
      outcome.occupancy = OCC_W'(sorted_entries.size());
      return outcome;
   endfunction

   always @(posedge clock) begin : scoreboard
      queue_outcome_type awaited;
      if (reset) begin
         sorted_entries.delete();
         awaited_outcomes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               $display("%0t unexpected result beat: status %0d occupancy %0d",
                        $time, rsp_status, rsp_occupancy);
               fail_tally++;
            end else begin
               awaited = awaited_outcomes.pop_front();
               if (rsp_popped_data !== awaited.popped_data) begin
                  $display("%0t popped_data: expected %h actual %h",
                           $time, awaited.popped_data, rsp_popped_data);
                  fail_tally++;
               end
               if (rsp_status !== awaited.status) begin
                  $display("%0t status: expected %0d actual %0d",
                           $time, awaited.status, rsp_status);
                  fail_tally++;
               end
               if (rsp_occupancy !== awaited.occupancy) begin
                  $display("%0t occupancy: expected %0d actual %0d",
                           $time, awaited.occupancy, rsp_occupancy);
                  fail_tally++;
               end
            end
         end
         if (req_valid && req_ready)
            awaited_outcomes.push_back(apply_operation(req_func, req_item_data,
                                                       req_priority_req));
      end
      mismatches  <= fail_tally;
      outstanding <= awaited_outcomes.size();
   end

endmodule

FILE: bench/min_priority_queue_sorted_tb.sv
// top of the sorted priority queue bench: clock, reset, request stimulus, result stalls, verdict
`timescale 1ns / 100ps
module min_priority_queue_sorted_tb;
   import mpqs_pkg::*;

   localparam int DEPTH        = 16;
   localparam int DATA_WIDTH   = 32;
   localparam int PRIO_WIDTH   = 16;
   localparam int OCC_W        = $clog2(DEPTH + 1);
   localparam int RANDOM_BEATS = 1050;
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum int {
      DRAIN_FREE,
      DRAIN_JITTER,
      DRAIN_STALLS
   } drain_mode_type;

   logic                         clock            = 1'b0;
   logic                         reset            = 1'b1;
   logic                         req_valid        = 1'b0;
   logic                         req_ready;
   logic                         req_func         = FUNC_INSERT;
   logic [DATA_WIDTH-1:0]        req_item_data    = '0;
   logic signed [PRIO_WIDTH-1:0] req_priority_req = '0;
   logic                         rsp_valid;
   logic                         rsp_ready        = 1'b0;
   logic [DATA_WIDTH-1:0]        rsp_popped_data;
   status_type                   rsp_status;
   logic [OCC_W-1:0]             rsp_occupancy;
   int                           mismatches;
   int                           outstanding;
   int                           cycle_count      = 0;
   drain_mode_type               drain_mode       = DRAIN_FREE;
   int                           mode_left        = 0;
   int                           stall_left       = 0;

   always #5 clock = ~clock;

   min_priority_queue_sorted #(
      .DEPTH(DEPTH),
      .DATA_WIDTH(DATA_WIDTH),
      .PRIO_WIDTH(PRIO_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_item_data(req_item_data),
      .req_priority_req(req_priority_req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_popped_data(rsp_popped_data),
      .rsp_status(rsp_status),
      .rsp_occupancy(rsp_occupancy)
   );

   min_priority_queue_sorted_checker #(
      .DEPTH(DEPTH),
      .DATA_WIDTH(DATA_WIDTH),
      .PRIO_WIDTH(PRIO_WIDTH)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_item_data(req_item_data),
      .req_priority_req(req_priority_req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_popped_data(rsp_popped_data),
      .rsp_status(rsp_status),
      .rsp_occupancy(rsp_occupancy),
      .mismatches(mismatches),
      .outstanding(outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side stalls
   always @(posedge clock) begin
      if (mode_left == 0) begin
         drain_mode <= drain_mode_type'($urandom_range(DRAIN_FREE, DRAIN_STALLS));
         mode_left  <= $urandom_range(50, 300);
      end else begin
         mode_left <= mode_left - 1;
      end
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         case (drain_mode)
            DRAIN_FREE: begin
               rsp_ready <= 1'b1;
            end
            DRAIN_JITTER: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               if ($urandom_range(0, 7) == 0) begin
                  rsp_ready  <= 1'b0;
                  stall_left <= $urandom_range(1, 12);
               end else begin
                  rsp_ready <= 1'b1;
               end
            end
         endcase
      end
   end

   task automatic send_beat(input logic func, input logic [DATA_WIDTH-1:0] data,
                            input logic signed [PRIO_WIDTH-1:0] prio);
      req_valid        <= 1'b1;
      req_func         <= func;
      req_item_data    <= data;
      req_priority_req <= prio;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (outstanding != 0);
   endtask

   function automatic logic signed [PRIO_WIDTH-1:0] pick_priority();
      logic signed [PRIO_WIDTH-1:0] prio;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            // narrow band so equal priorities are common
            prio = PRIO_WIDTH'($urandom_range(0, 8));
            prio = prio - PRIO_WIDTH'(4);
         end
         4: begin
            case ($urandom_range(0, 3))
               0:       prio = 16'sh8000;
               1:       prio = 16'sh7fff;
               2:       prio = 16'sh0000;
               default: prio = 16'shffff;
            endcase
         end
         default: prio = PRIO_WIDTH'($urandom);
      endcase
      return prio;
   endfunction

   initial begin
      int sent;
      int burst;
      int gap;
      int insert_pct;
      sent       = 0;
      insert_pct = 50;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_beat(FUNC_POP, 32'hffff_ffff, 16'sh7fff);
      send_beat(FUNC_INSERT, 32'h0000_0000, 16'sh0000);
      send_beat(FUNC_INSERT, 32'hffff_ffff, 16'sh7fff);
      send_beat(FUNC_INSERT, 32'ha5a5_a5a5, 16'sh8000);
      send_beat(FUNC_INSERT, 32'h5a5a_5a5a, 16'sh0000);
      send_beat(FUNC_INSERT, 32'h1234_5678, 16'shffff);
      for (int i = 0; i < DEPTH - 5; i++)
         send_beat(FUNC_INSERT, $urandom, (i % 2 == 1) ? 16'sh8000 : 16'sh7fff);
      send_beat(FUNC_INSERT, 32'hdead_beef, 16'sh8000);
      repeat (5) send_beat(FUNC_POP, $urandom, PRIO_WIDTH'($urandom));
      wait_drained();

      while (sent < RANDOM_BEATS) begin
         burst = $urandom_range(1, 12);
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 2))
               0:       insert_pct = 85;
               1:       insert_pct = 50;
               default: insert_pct = 20;
            endcase
         end
         repeat (burst) begin
            if ($urandom_range(0, 99) < insert_pct)
               send_beat(FUNC_INSERT, $urandom, pick_priority());
            else
               send_beat(FUNC_POP, $urandom, PRIO_WIDTH'($urandom));
            sent++;
         end
         if ($urandom_range(0, 15) == 0) begin
            wait_drained();
         end else begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
